[rtl/core/ssq_pkg.sv]
// shared types, constants and codes of the sorted event queue
package ssq_pkg;

    localparam int DEF_QUEUE_DEPTH = 256;
    localparam int DEF_MAX_POP     = 16;
    localparam int DEF_CNT_W       = $clog2(DEF_QUEUE_DEPTH + 1);

    localparam int TICK_W = 32;
    localparam int PAY_W  = 64;
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] POP_LIMIT_RESET = CFG_W'(16);

    // due flags are summed in groups of this size before the final add
    localparam int POP_GROUP = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_INSERT     = 2'd1,
        CELL_SHIFT      = 2'd2,
        CELL_SHIFT_KEEP = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [PAY_W-1:0]  pay;
    } t_cell;

    typedef struct packed {
        t_cell_op          op;
        logic [TICK_W-1:0] tick;
        logic [PAY_W-1:0]  pay;
    } t_cell_ctl;

endpackage

[rtl/core/ssq_if.sv]
// channel interfaces: command items, result items, pop limit writes
interface ssq_cmd_if import ssq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TICK_W-1:0] tick;
    logic [BYTE_W-1:0] port;
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] data1;
    logic [BYTE_W-1:0] data2;
    logic [TICK_W-1:0] param;

    modport source (output valid, command, tick, port, status, data1, data2, param,
                    input ready);
    modport sink (input valid, command, tick, port, status, data1, data2, param,
                  output ready);
endinterface

interface ssq_res_if import ssq_pkg::*; #(
    parameter int CNT_W = DEF_CNT_W
);
    logic              valid;
    logic              ready;
    logic              has_event;
    logic [TICK_W-1:0] ev_tick;
    logic [BYTE_W-1:0] ev_port;
    logic [BYTE_W-1:0] ev_status;
    logic [BYTE_W-1:0] ev_data1;
    logic [BYTE_W-1:0] ev_data2;
    logic [TICK_W-1:0] ev_param;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  removed_count;
    logic [CNT_W-1:0]  occupancy;
    logic [TICK_W-1:0] tail_tick;

    modport source (output valid, has_event, ev_tick, ev_port, ev_status, ev_data1,
                    ev_data2, ev_param, last, accepted, removed_count, occupancy,
                    tail_tick, input ready);
    modport sink (input valid, has_event, ev_tick, ev_port, ev_status, ev_data1,
                  ev_data2, ev_param, last, accepted, removed_count, occupancy,
                  tail_tick, output ready);
endinterface

interface ssq_cfg_if import ssq_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] pop_limit;

    modport source (output valid, pop_limit, input ready);
    modport sink (input valid, pop_limit, output ready);
endinterface

[rtl/core/ssq_cell.sv]
// one queue slot: holds an entry and moves it to or from its neighbors
module ssq_cell import ssq_pkg::*; #(
    parameter int CW  = DEF_CNT_W,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  t_cell         i_left,
    input  logic          i_left_above,
    input  t_cell         i_right,
    input  t_cell         i_head,
    output t_cell         o_data,
    output logic          o_above,
    output logic          o_due
);

    t_cell r_data;
    t_cell n_data;
    logic  w_occ;

    assign w_occ   = i_count > CW'(IDX);
    assign o_above = w_occ && (r_data.tick > i_ctl.tick);
    assign o_due   = w_occ && (r_data.tick <= i_ctl.tick);
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            CELL_HOLD: n_data = r_data;
            CELL_INSERT: begin
                // later ticks move one slot up, the new entry lands in the gap
                if (i_left_above) begin
                    n_data = i_left;
                end else if (o_above || (i_count == CW'(IDX))) begin
                    n_data = '{tick: i_ctl.tick, pay: i_ctl.pay};
                end
            end
            CELL_SHIFT: n_data = i_right;
            CELL_SHIFT_KEEP: begin
                // kept head wraps around to the current tail slot
                if (i_count == CW'(IDX + 1)) begin
                    n_data = i_head;
                end else begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

[rtl/core/ssq_chain.sv]
// row of queue slots, slot 0 is the head
module ssq_chain import ssq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CW          = DEF_CNT_W,
    parameter int NP          = DEF_MAX_POP
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    output t_cell         o_head,
    output logic [NP-1:0] o_due
);

    t_cell w_data  [QUEUE_DEPTH];
    logic  w_above [QUEUE_DEPTH];
    logic  w_due   [QUEUE_DEPTH];

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell w_left;
        t_cell w_right;
        logic  w_left_above;

        if (g == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_above = 1'b0;
        end else begin : g_inner_left
            assign w_left       = w_data[g-1];
            assign w_left_above = w_above[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_right
            assign w_right = w_data[g+1];
        end

        ssq_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_count      (i_count),
            .i_left       (w_left),
            .i_left_above (w_left_above),
            .i_right      (w_right),
            .i_head       (w_data[0]),
            .o_data       (w_data[g]),
            .o_above      (w_above[g]),
            .o_due        (w_due[g])
        );
    end

    for (genvar k = 0; k < NP; k++) begin : g_due
        assign o_due[k] = w_due[k];
    end

    assign o_head = w_data[0];

endmodule

[rtl/core/stable_tick_sorted_event_queue.sv]
// sorted event queue top level: command sequencer, pop counter, result register
//
//   channel  | dir | handshake     | carries
//   i_cmd    | in  | valid / ready | command, tick, port, status, data1, data2, param
//   i_cfg    | in  | valid / ready | pop_limit (always ready)
//   o_res    | out | valid / ready | one result item, registered
//
// insert reports from ST_INS, clear from ST_DONE; flush walks every held entry, as
// every entry passes once through the chain's head slot, and reports from ST_DONE.
// pop counts the due head slots in ST_SCAN, ST_GSUM and ST_PSET, then emits one event
// per result item from ST_EMIT (one empty result when none is due).
// reset clears state, fill count, output valid and pop limit; slots need no clearing.
// a stalled result holds in the output register; the next command is taken, and
// waits for the register only when it has its own result to deliver.
module stable_tick_sorted_event_queue import ssq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int MAX_POP     = DEF_MAX_POP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssq_cmd_if.sink    i_cmd,
    ssq_cfg_if.sink    i_cfg,
    ssq_res_if.source  o_res
);

    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int NP   = (MAX_POP < QUEUE_DEPTH) ? MAX_POP : QUEUE_DEPTH;
    localparam int PW   = $clog2(NP + 1);
    localparam int LW   = $clog2(MAX_POP + 1);
    localparam int NG   = (NP + POP_GROUP - 1) / POP_GROUP;
    localparam int NPAD = NG * POP_GROUP;
    localparam int GSW  = $clog2(POP_GROUP + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_INS   = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_GSUM  = 8'b0000_1000,
        ST_PSET  = 8'b0001_0000,
        ST_EMIT  = 8'b0010_0000,
        ST_FLUSH = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_left;
    logic [CW-1:0]     r_removed;
    logic [CW-1:0]     r_cnt_final;
    logic [TICK_W-1:0] r_arg_tick;
    logic [PAY_W-1:0]  r_arg_pay;
    logic [TICK_W-1:0] r_tail;
    logic [CFG_W-1:0]  r_pop_limit;
    logic [NP-1:0]     r_due;
    logic [GSW-1:0]    r_grp [NG];
    logic [PW-1:0]     r_npop;
    logic [PW-1:0]     r_emitted;

    logic              r_out_valid;
    logic              r_o_has;
    logic [TICK_W-1:0] r_o_tick;
    logic [PAY_W-1:0]  r_o_pay;
    logic              r_o_last;
    logic              r_o_acc;
    logic [CW-1:0]     r_o_removed;
    logic [CW-1:0]     r_o_occ;
    logic [TICK_W-1:0] r_o_tail;

    logic              n_o_has;
    logic [TICK_W-1:0] n_o_tick;
    logic [PAY_W-1:0]  n_o_pay;
    logic              n_o_last;
    logic              n_o_acc;
    logic [CW-1:0]     n_o_removed;
    logic [CW-1:0]     n_o_occ;
    logic [TICK_W-1:0] n_o_tail;

    t_cell_op          w_op;
    t_cell_ctl         w_ctl;
    t_cell             w_head;
    logic [NP-1:0]     w_due;
    logic              w_out_free;
    logic              w_load;
    logic              w_full;
    logic              w_keep;
    logic              w_ins_tail;
    logic              w_cmd_take;
    logic [LW-1:0]     w_lim;
    logic [NPAD-1:0]   w_pad;
    logic [GSW-1:0]    w_grp [NG];
    logic [PW-1:0]     w_total;
    logic [PW-1:0]     w_npop;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_cmd_take  = i_cmd.valid && (r_state == ST_IDLE);

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_keep     = (w_head.tick < r_arg_tick);
    assign w_ins_tail = (r_count == '0) || (r_tail <= r_arg_tick);

    always_comb begin
        w_ctl.op   = w_op;
        w_ctl.tick = r_arg_tick;
        w_ctl.pay  = r_arg_pay;
    end

    ssq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW),
        .NP          (NP)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_count (r_count),
        .o_head  (w_head),
        .o_due   (w_due)
    );

    // pop limit of zero acts as one, above the head window acts as the window
    always_comb begin
        if (r_pop_limit == '0) begin
            w_lim = LW'(1);
        end else if (int'(r_pop_limit) > MAX_POP) begin
            w_lim = LW'(MAX_POP);
        end else begin
            w_lim = LW'(r_pop_limit);
        end
    end

    // due flags form a prefix, their sum is the number of due head events
    always_comb begin
        w_pad = NPAD'(r_due);
        for (int g = 0; g < NG; g++) begin
            w_grp[g] = '0;
            for (int j = 0; j < POP_GROUP; j++) begin
                w_grp[g] = w_grp[g] + GSW'(w_pad[g*POP_GROUP+j]);
            end
        end
    end

    always_comb begin
        w_total = '0;
        for (int g = 0; g < NG; g++) begin
            w_total = w_total + PW'(r_grp[g]);
        end
        w_npop = (int'(w_total) < int'(w_lim)) ? w_total : PW'(w_lim);
    end

    always_comb begin
        w_op        = CELL_HOLD;
        w_load      = 1'b0;
        n_o_has     = 1'b0;
        n_o_tick    = '0;
        n_o_pay     = '0;
        n_o_last    = 1'b1;
        n_o_acc     = 1'b0;
        n_o_removed = '0;
        n_o_occ     = r_count;
        n_o_tail    = (r_count == '0) ? '0 : r_tail;
        unique case (r_state)
            ST_INS: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (!w_full) begin
                        w_op     = CELL_INSERT;
                        n_o_acc  = 1'b1;
                        n_o_occ  = r_count + CW'(1);
                        n_o_tail = w_ins_tail ? r_arg_tick : r_tail;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    n_o_occ  = r_cnt_final;
                    n_o_tail = (r_cnt_final == '0) ? '0 : r_tail;
                    if (r_npop != '0) begin
                        w_op     = CELL_SHIFT;
                        n_o_has  = 1'b1;
                        n_o_tick = w_head.tick;
                        n_o_pay  = w_head.pay;
                        n_o_last = ((r_emitted + PW'(1)) == r_npop);
                    end
                end
            end
            ST_FLUSH: begin
                if (r_left != '0) begin
                    w_op = w_keep ? CELL_SHIFT_KEEP : CELL_SHIFT;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    n_o_removed = r_removed;
                end
            end
            default: w_op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pop_limit <= POP_LIMIT_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_pop_limit <= i_cfg.pop_limit;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        unique case (t_cmd'(i_cmd.command))
                            CMD_INSERT: r_state <= ST_INS;
                            CMD_POP:    r_state <= ST_SCAN;
                            CMD_FLUSH:  r_state <= ST_FLUSH;
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_state <= ST_DONE;
                            end
                            default:    r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_INS: begin
                    if (w_out_free) begin
                        if (!w_full) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: r_state <= ST_GSUM;
                ST_GSUM: r_state <= ST_PSET;
                ST_PSET: r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (w_out_free) begin
                        if (r_npop != '0) begin
                            r_count <= r_count - CW'(1);
                        end
                        if ((r_npop == '0) || n_o_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (r_left != '0) begin
                        if (!w_keep) begin
                            r_count <= r_count - CW'(1);
                        end
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd_take) begin
            r_arg_tick <= i_cmd.tick;
            r_arg_pay  <= {i_cmd.port, i_cmd.status, i_cmd.data1, i_cmd.data2, i_cmd.param};
            r_left     <= r_count;
            r_removed  <= '0;
        end
        if ((w_op == CELL_INSERT) && w_ins_tail) begin
            r_tail <= r_arg_tick;
        end
        if (r_state == ST_SCAN) begin
            r_due <= w_due;
        end
        if (r_state == ST_GSUM) begin
            r_grp <= w_grp;
        end
        if (r_state == ST_PSET) begin
            r_npop      <= w_npop;
            r_cnt_final <= r_count - CW'(w_npop);
            r_emitted   <= '0;
        end
        if ((r_state == ST_EMIT) && (w_op == CELL_SHIFT)) begin
            r_emitted <= r_emitted + PW'(1);
        end
        if ((r_state == ST_FLUSH) && (r_left != '0)) begin
            r_left <= r_left - CW'(1);
            // kept entries come out in tick order, so the last kept is the tail
            if (w_keep) begin
                r_tail <= w_head.tick;
            end else begin
                r_removed <= r_removed + CW'(1);
            end
        end
        if (w_load) begin
            r_o_has     <= n_o_has;
            r_o_tick    <= n_o_tick;
            r_o_pay     <= n_o_pay;
            r_o_last    <= n_o_last;
            r_o_acc     <= n_o_acc;
            r_o_removed <= n_o_removed;
            r_o_occ     <= n_o_occ;
            r_o_tail    <= n_o_tail;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.has_event     = r_o_has;
    assign o_res.ev_tick       = r_o_tick;
    assign o_res.ev_port       = r_o_pay[63:56];
    assign o_res.ev_status     = r_o_pay[55:48];
    assign o_res.ev_data1      = r_o_pay[47:40];
    assign o_res.ev_data2      = r_o_pay[39:32];
    assign o_res.ev_param      = r_o_pay[31:0];
    assign o_res.last          = r_o_last;
    assign o_res.accepted      = r_o_acc;
    assign o_res.removed_count = r_o_removed;
    assign o_res.occupancy     = r_o_occ;
    assign o_res.tail_tick     = r_o_tail;

endmodule

[rtl/core/ssq_chk.sv]
// port checker for the sorted event queue and its bind to the top level
module ssq_chk import ssq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               i_ready,
    input logic                               i_has_event,
    input logic                               i_last,
    input logic                               i_accepted,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_occupancy,
    input logic [TICK_W-1:0]                  i_tail_tick,
    input logic [TICK_W-1:0]                  i_ev_tick
);

    // a stalled result item stays valid and keeps its occupancy, last flag and event tick
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
        (i_valid && $stable(i_occupancy) && $stable(i_last) && $stable(i_ev_tick)))
        else $error("stalled result item changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_has_event) |-> i_last)
        else $error("result item without event is not last");

    a_accept_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_accepted) |-> ((i_occupancy != '0) && !i_has_event))
        else $error("stored insert reports empty queue or an event");

    a_empty_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_occupancy == '0)) |-> (i_tail_tick == '0))
        else $error("empty queue reports nonzero tail tick");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (int'(i_occupancy) <= QUEUE_DEPTH))
        else $error("occupancy above queue depth");

endmodule

bind stable_tick_sorted_event_queue ssq_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ssq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_has_event (o_res.has_event),
    .i_last      (o_res.last),
    .i_accepted  (o_res.accepted),
    .i_occupancy (o_res.occupancy),
    .i_tail_tick (o_res.tail_tick),
    .i_ev_tick   (o_res.ev_tick)
);

[bench/stable_tick_sorted_event_queue_tb.sv]
// testbench for the sorted event queue: command items checked against a shadow queue
module stable_tick_sorted_event_queue_tb;
    import ssq_pkg::*;

    localparam int DEPTH   = DEF_QUEUE_DEPTH;
    localparam int POP_MAX = DEF_MAX_POP;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_cmd              command;
        logic [TICK_W-1:0] tick;
        logic [BYTE_W-1:0] port;
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] data1;
        logic [BYTE_W-1:0] data2;
        logic [TICK_W-1:0] param;
    } t_cmd_item;

    typedef struct {
        logic              has_event;
        logic [TICK_W-1:0] ev_tick;
        logic [BYTE_W-1:0] ev_port;
        logic [BYTE_W-1:0] ev_status;
        logic [BYTE_W-1:0] ev_data1;
        logic [BYTE_W-1:0] ev_data2;
        logic [TICK_W-1:0] ev_param;
        logic              last;
        logic              accepted;
        logic [8:0]        removed_count;
        logic [8:0]        occupancy;
        logic [TICK_W-1:0] tail_tick;
    } t_queue_result;

    class t_event_queue_shadow;
        logic [TICK_W-1:0] shadow_ticks[$];
        logic [PAY_W-1:0]  shadow_pays[$];
        logic [CFG_W-1:0]  pop_limit;
        t_queue_result     result_backlog[$];
        int errors;
        int n_cmds;
        int n_results;
        int n_events;
        int n_refused;
        int peak_occ;

        function new();
            pop_limit = POP_LIMIT_RESET;
            errors = 0;
            n_cmds = 0;
            n_results = 0;
            n_events = 0;
            n_refused = 0;
            peak_occ = 0;
        endfunction

        function void make_result(input logic has, input logic [TICK_W-1:0] t,
                                  input logic [PAY_W-1:0] pay, input logic lst,
                                  input logic acc, input int removed);
            t_queue_result r;
            int cnt;
            cnt = shadow_ticks.size();
            r.has_event     = has;
            r.ev_tick       = has ? t : '0;
            r.ev_port       = has ? pay[63:56] : '0;
            r.ev_status     = has ? pay[55:48] : '0;
            r.ev_data1      = has ? pay[47:40] : '0;
            r.ev_data2      = has ? pay[39:32] : '0;
            r.ev_param      = has ? pay[31:0] : '0;
            r.last          = lst;
            r.accepted      = acc;
            r.removed_count = 9'(removed);
            r.occupancy     = 9'(cnt);
            r.tail_tick     = cnt > 0 ? shadow_ticks[cnt-1] : '0;
            result_backlog.push_back(r);
        endfunction

        function void note_command(input t_cmd_item c);
            logic [PAY_W-1:0]  pay;
            logic [TICK_W-1:0] out_t[$];
            logic [PAY_W-1:0]  out_p[$];
            logic [TICK_W-1:0] kept_t[$];
            logic [PAY_W-1:0]  kept_p[$];
            int i;
            int lim;
            int removed;
            n_cmds++;
            pay = {c.port, c.status, c.data1, c.data2, c.param};
            case (c.command)
                CMD_INSERT: begin
                    if (shadow_ticks.size() < DEPTH) begin
                        // equal ticks go behind the ones already held
                        i = shadow_ticks.size();
                        while (i > 0 && shadow_ticks[i-1] > c.tick) i--;
                        shadow_ticks.insert(i, c.tick);
                        shadow_pays.insert(i, pay);
                        make_result(1'b0, '0, '0, 1'b1, 1'b1, 0);
                    end else begin
                        n_refused++;
                        make_result(1'b0, '0, '0, 1'b1, 1'b0, 0);
                    end
                end
                CMD_POP: begin
                    lim = (pop_limit == 0) ? 1 : (pop_limit > POP_MAX ? POP_MAX : pop_limit);
                    while (shadow_ticks.size() > 0 && shadow_ticks[0] <= c.tick
                           && out_t.size() < lim) begin
                        out_t.push_back(shadow_ticks.pop_front());
                        out_p.push_back(shadow_pays.pop_front());
                    end
                    n_events += out_t.size();
                    if (out_t.size() == 0) begin
                        make_result(1'b0, '0, '0, 1'b1, 1'b0, 0);
                    end
                    for (i = 0; i < out_t.size(); i++) begin
                        make_result(1'b1, out_t[i], out_p[i], i == out_t.size() - 1, 1'b0, 0);
                    end
                end
                CMD_FLUSH: begin
                    removed = 0;
                    for (i = 0; i < shadow_ticks.size(); i++) begin
                        if (shadow_ticks[i] >= c.tick) begin
                            removed++;
                        end else begin
                            kept_t.push_back(shadow_ticks[i]);
                            kept_p.push_back(shadow_pays[i]);
                        end
                    end
                    shadow_ticks = kept_t;
                    shadow_pays = kept_p;
                    make_result(1'b0, '0, '0, 1'b1, 1'b0, removed);
                end
                default: begin
                    shadow_ticks.delete();
                    shadow_pays.delete();
                    make_result(1'b0, '0, '0, 1'b1, 1'b0, 0);
                end
            endcase
            if (shadow_ticks.size() > peak_occ) peak_occ = shadow_ticks.size();
        endfunction

        function bit field_ok(input string name, input logic [31:0] want,
                              input logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(input t_queue_result got);
            t_queue_result want;
            bit ok;
            n_results++;
            if (result_backlog.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual ev_tick %h occ %0d",
                         $time, got.ev_tick, got.occupancy);
                errors++;
                return;
            end
            want = result_backlog.pop_front();
            ok = 1'b1;
            ok &= field_ok("has_event", want.has_event, got.has_event);
            ok &= field_ok("ev_tick", want.ev_tick, got.ev_tick);
            ok &= field_ok("ev_port", want.ev_port, got.ev_port);
            ok &= field_ok("ev_status", want.ev_status, got.ev_status);
            ok &= field_ok("ev_data1", want.ev_data1, got.ev_data1);
            ok &= field_ok("ev_data2", want.ev_data2, got.ev_data2);
            ok &= field_ok("ev_param", want.ev_param, got.ev_param);
            ok &= field_ok("last", want.last, got.last);
            ok &= field_ok("accepted", want.accepted, got.accepted);
            ok &= field_ok("removed_count", want.removed_count, got.removed_count);
            ok &= field_ok("occupancy", want.occupancy, got.occupancy);
            ok &= field_ok("tail_tick", want.tail_tick, got.tail_tick);
            if (!ok) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   rx_hold_left;
    t_event_queue_shadow shadow;

    ssq_cmd_if cmd_ch();
    ssq_cfg_if cfg_ch();
    ssq_res_if res_ch();

    stable_tick_sorted_event_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: long hold first if requested, otherwise random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready = 1'b0;
        end else if (rx_hold_left > 0) begin
            res_ch.ready = 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            res_ch.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_queue_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.has_event     = res_ch.has_event;
            got.ev_tick       = res_ch.ev_tick;
            got.ev_port       = res_ch.ev_port;
            got.ev_status     = res_ch.ev_status;
            got.ev_data1      = res_ch.ev_data1;
            got.ev_data2      = res_ch.ev_data2;
            got.ev_param      = res_ch.ev_param;
            got.last          = res_ch.last;
            got.accepted      = res_ch.accepted;
            got.removed_count = res_ch.removed_count;
            got.occupancy     = res_ch.occupancy;
            got.tail_tick     = res_ch.tail_tick;
            shadow.check_result(got);
        end
    end

    task automatic send_cmd(input t_cmd_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid   = 1'b1;
        cmd_ch.command = it.command;
        cmd_ch.tick    = it.tick;
        cmd_ch.port    = it.port;
        cmd_ch.status  = it.status;
        cmd_ch.data1   = it.data1;
        cmd_ch.data2   = it.data2;
        cmd_ch.param   = it.param;
        do @(posedge i_clk); while (!cmd_ch.ready);
        shadow.note_command(it);
    endtask

    task automatic issue(input t_cmd cmd, input logic [TICK_W-1:0] t,
                         input logic [PAY_W-1:0] pay);
        t_cmd_item it;
        it.command = cmd;
        it.tick    = t;
        {it.port, it.status, it.data1, it.data2, it.param} = pay;
        send_cmd(it);
    endtask

    function automatic logic [PAY_W-1:0] any_pay();
        return {$urandom, $urandom};
    endfunction

    // every item has a result, so an empty backlog means the block is idle
    task automatic drain();
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
        while (shadow.result_backlog.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_pop_limit(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.pop_limit = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        shadow.pop_limit = v;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic t_cmd_item random_item(input logic [TICK_W-1:0] base);
        t_cmd_item it;
        int roll;
        roll = $urandom_range(99);
        {it.port, it.status, it.data1, it.data2, it.param} = any_pay();
        if (roll < 55) it.command = CMD_INSERT;
        else if (roll < 82) it.command = CMD_POP;
        else if (roll < 96) it.command = CMD_FLUSH;
        else it.command = CMD_CLEAR;
        case ($urandom_range(9))
            0: it.tick = $urandom;
            1: it.tick = $urandom_range(1) ? '1 : '0;
            default: it.tick = base + $urandom_range(0, 48);
        endcase
        return it;
    endfunction

    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        logic [TICK_W-1:0] window;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        window = $urandom;
        repeat (count) begin
            // let sequencer time creep forward now and then
            if ($urandom_range(9) == 0) window = window + $urandom_range(1, 16);
            send_cmd(random_item(window));
        end
        drain();
    endtask

    initial begin
        logic [TICK_W-1:0] base;
        shadow = new();
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_INSERT;
        cmd_ch.tick = '0;
        cmd_ch.port = '0;
        cmd_ch.status = '0;
        cmd_ch.data1 = '0;
        cmd_ch.data2 = '0;
        cmd_ch.param = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.pop_limit = '0;
        res_ch.ready = 1'b0;
        tx_idle_pct = 31;
        rx_idle_pct = 85;
        rx_hold_left = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, with the pop limit still at its reset value
        issue(CMD_POP, '1, any_pay());
        issue(CMD_FLUSH, '0, any_pay());
        issue(CMD_CLEAR, '0, any_pay());
        issue(CMD_INSERT, 32'd100, '1);
        issue(CMD_INSERT, 32'd100, '0);
        issue(CMD_INSERT, 32'd50, any_pay());
        issue(CMD_INSERT, 32'd0, any_pay());
        issue(CMD_INSERT, '1, any_pay());
        issue(CMD_INSERT, 32'd100, any_pay());
        issue(CMD_POP, 32'd49, any_pay());
        issue(CMD_POP, 32'd0, any_pay());
        issue(CMD_POP, 32'd100, any_pay());
        issue(CMD_FLUSH, '1, any_pay());
        issue(CMD_INSERT, 32'd7, any_pay());
        issue(CMD_INSERT, 32'd3, any_pay());
        issue(CMD_FLUSH, 32'd5, any_pay());
        issue(CMD_CLEAR, '0, any_pay());
        issue(CMD_INSERT, 32'd2, any_pay());
        issue(CMD_INSERT, 32'd1, any_pay());
        issue(CMD_INSERT, 32'd2, any_pay());
        issue(CMD_POP, '1, any_pay());
        drain();

        // fill to the brim behind a long receiver hold; limit 0 behaves as 1
        set_pop_limit(CFG_W'(0));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left = HOLD_CYCLES;
        base = $urandom_range(32'h4000_0000, 32'h0000_1000);
        repeat (DEPTH) issue(CMD_INSERT, base + $urandom_range(0, 40), any_pay());
        issue(CMD_INSERT, '0, any_pay());
        issue(CMD_INSERT, '1, any_pay());
        issue(CMD_POP, '1, any_pay());
        issue(CMD_INSERT, base + 20, any_pay());
        drain();

        // limit above the maximum behaves as the maximum
        set_pop_limit(CFG_W'(31));
        issue(CMD_POP, '1, any_pay());
        repeat (POP_MAX) issue(CMD_INSERT, base + $urandom_range(0, 40), any_pay());
        issue(CMD_FLUSH, '0, any_pay());
        drain();

        set_pop_limit(CFG_W'(1));
        run_random(57, 31, 85);
        set_pop_limit(CFG_W'(16));
        run_random(57, 85, 31);
        set_pop_limit(CFG_W'(5));
        run_random(57, 0, 0);

        // a flush of a full queue is the slowest command
        repeat (DEPTH + 40) @(posedge i_clk);

        while (shadow.result_backlog.size() != 0) begin
            void'(shadow.result_backlog.pop_front());
            $display("%0t: result never arrived", $time);
            shadow.errors++;
        end
        $display("run covered %0d commands, %0d result items, %0d events popped",
                 shadow.n_cmds, shadow.n_results, shadow.n_events);
        $display("refused inserts %0d, peak occupancy %0d, pop limits 0 1 5 16 31",
                 shadow.n_refused, shadow.peak_occ);
        if (shadow.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
